FILE: hw/rtl/gest_pkg.sv
// Shared constants, codes, types and helpers of the generational entity slot table.
package gest_pkg;

    localparam int CAPACITY    = 1024;
    localparam int SLOT_W      = $clog2(CAPACITY);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int GEN_W       = 8;
    localparam int HID_W       = 24;
    localparam int HANDLE_W    = 32;
    localparam int COMP_LIMIT  = 16;
    localparam int SIG_W       = 16;
    localparam int COMP_IDX_W  = 4;
    localparam int SYS_LIMIT   = 4;
    localparam int NUM_SYS     = 4;
    localparam int CMD_W       = 3;
    localparam int COMP_W      = 5;
    localparam int STATUS_W    = 3;
    localparam int MATCH_W     = 4;
    localparam int CIU_W       = 5;
    localparam int SIU_W       = 3;
    localparam int LIM_W       = 6;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = 3;

    // Request codes
    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ATTACH  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DETACH  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ATTACHED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADCOMP  = 3'd4;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_COMPONENTS = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYSTEMS    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIG0       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIG1       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SIG2       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SIG3       = 3'd5;

    typedef enum logic [2:0] {
        RK_INVALID,
        RK_FULL,
        RK_BADCOMP,
        RK_CREATE,
        RK_DESTROY,
        RK_COMP
    } res_kind_t;

    typedef struct packed {
        logic      load;
        logic      rd_slot;
        logic      rd_last;
        logic      do_create;
        logic      do_comp;
        logic      do_move;
        logic      do_release;
        logic      res_load;
        res_kind_t res_kind;
    } ctl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             comp_ok;
        logic             map_ok;
        logic             gen_ok;
    } ctl_stat_t;

    typedef struct packed {
        logic [CIU_W-1:0]                  comps;
        logic [SIU_W-1:0]                  systems;
        logic [NUM_SYS-1:0][SIG_W-1:0]     sigs;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] entity_handle;
        logic [SLOT_W-1:0]   slot;
        logic [SIG_W-1:0]    signature;
        logic                present;
        logic [MATCH_W-1:0]  system_match;
        logic [CNT_W-1:0]    live_entities;
    } result_t;

    // Systems whose required bits are all present in sig
    function automatic logic [MATCH_W-1:0] match_mask(input logic [SIG_W-1:0] sig,
                                                      input cfg_t cfg);
        logic [SIU_W-1:0]   n;
        logic [MATCH_W-1:0] m;
        n = (cfg.systems > SIU_W'(SYS_LIMIT)) ? SIU_W'(SYS_LIMIT) : cfg.systems;
        m = '0;
        for (int s = 0; s < NUM_SYS; s++)
        begin
            if ((SIU_W'(s) < n) && ((sig & cfg.sigs[s]) == cfg.sigs[s]))
            begin
                m[s] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/gest_if.sv
// Request and result channel interfaces of the slot table.
interface gest_in_if import gest_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [HANDLE_W-1:0] handle;
    logic [COMP_W-1:0]   component;
    modport source (output valid, cmd, handle, component, input ready);
    modport sink (input valid, cmd, handle, component, output ready);
endinterface

interface gest_out_if import gest_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] entity_handle;
    logic [SLOT_W-1:0]   slot;
    logic [SIG_W-1:0]    signature;
    logic                present;
    logic [MATCH_W-1:0]  system_match;
    logic [CNT_W-1:0]    live_entities;
    modport source (output valid, status, entity_handle, slot, signature, present,
                    system_match, live_entities, input ready);
    modport sink (input valid, status, entity_handle, slot, signature, present,
                  system_match, live_entities, output ready);
endinterface

FILE: hw/rtl/gest_cfg.sv
// APB configuration registers of the slot table.
module gest_cfg import gest_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Decode the write beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_COMPONENTS: cfg_next.comps   = pwdata[CIU_W-1:0];
                REG_SYSTEMS:    cfg_next.systems = pwdata[SIU_W-1:0];
                REG_SIG0:       cfg_next.sigs[0] = pwdata[SIG_W-1:0];
                REG_SIG1:       cfg_next.sigs[1] = pwdata[SIG_W-1:0];
                REG_SIG2:       cfg_next.sigs[2] = pwdata[SIG_W-1:0];
                REG_SIG3:       cfg_next.sigs[3] = pwdata[SIG_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_COMPONENTS: prdata = APB_DATA_W'(cfg_reg.comps);
            REG_SYSTEMS:    prdata = APB_DATA_W'(cfg_reg.systems);
            REG_SIG0:       prdata = APB_DATA_W'(cfg_reg.sigs[0]);
            REG_SIG1:       prdata = APB_DATA_W'(cfg_reg.sigs[1]);
            REG_SIG2:       prdata = APB_DATA_W'(cfg_reg.sigs[2]);
            REG_SIG3:       prdata = APB_DATA_W'(cfg_reg.sigs[3]);
            default:        prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/gest_ctrl.sv
// Request sequencer of the slot table.
module gest_ctrl import gest_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_CHECK,
        S_MOVE,
        S_RELEASE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   comp_cmd;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign comp_cmd  = (stat.cmd == CMD_ATTACH) || (stat.cmd == CMD_DETACH)
                    || (stat.cmd == CMD_QUERY);

    // Step through the table accesses; a result waits until the output frees
    always_comb
    begin
        ctl        = '0;
        ctl.res_kind = RK_INVALID;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (stat.cmd == CMD_CREATE)
                begin
                    if (out_free)
                    begin
                        ctl.res_load  = 1'b1;
                        ctl.res_kind  = stat.full ? RK_FULL : RK_CREATE;
                        ctl.do_create = !stat.full;
                        state_next    = S_IDLE;
                    end
                end
                else if ((stat.cmd == CMD_DESTROY || (comp_cmd && stat.comp_ok))
                         && stat.map_ok)
                begin
                    ctl.rd_slot = 1'b1;
                    state_next  = S_CHECK;
                end
                else if (out_free)
                begin
                    ctl.res_load = 1'b1;
                    ctl.res_kind = (comp_cmd && !stat.comp_ok) ? RK_BADCOMP : RK_INVALID;
                    state_next   = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (stat.gen_ok && stat.cmd == CMD_DESTROY)
                begin
                    ctl.rd_last = 1'b1;
                    state_next  = S_MOVE;
                end
                else if (out_free)
                begin
                    ctl.res_load = 1'b1;
                    ctl.res_kind = stat.gen_ok ? RK_COMP : RK_INVALID;
                    ctl.do_comp  = stat.gen_ok;
                    state_next   = S_IDLE;
                end
            end
            S_MOVE:
            begin
                ctl.do_move = 1'b1;
                state_next  = S_RELEASE;
            end
            S_RELEASE:
            begin
                if (out_free)
                begin
                    ctl.do_release = 1'b1;
                    ctl.res_load   = 1'b1;
                    ctl.res_kind   = RK_DESTROY;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result beat valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/gest_dp.sv
// Slot table datapath: tables, counters, checks and the result register.
module gest_dp import gest_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  ctl_cmd_t            ctl,
    output ctl_stat_t           stat,
    input  logic [CMD_W-1:0]    in_cmd,
    input  logic [HANDLE_W-1:0] in_handle,
    input  logic [COMP_W-1:0]   in_component,
    output result_t             res
);

    // Tables
    logic [SLOT_W:0]   map_mem   [CAPACITY];
    logic [GEN_W-1:0]  gen_mem   [CAPACITY];
    logic [SLOT_W-1:0] sid_mem   [CAPACITY];
    logic [SIG_W-1:0]  sig_mem   [CAPACITY];
    logic [SLOT_W-1:0] stack_mem [CAPACITY];

    logic [SLOT_W:0]   map_q;
    logic [GEN_W-1:0]  gen_q;
    logic [SLOT_W-1:0] sid_q;
    logic [SIG_W-1:0]  sig_q;
    logic [SLOT_W-1:0] stack_q;

    // Counters and request registers
    logic [CNT_W-1:0]    live_reg, live_next;
    logic [CNT_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]    slot_hw_reg, slot_hw_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [COMP_W-1:0]   comp_reg;
    logic [SLOT_W-1:0]   slot_reg;
    result_t             res_reg, res_next;

    logic [HID_W-1:0]  hid;
    logic [SLOT_W-1:0] id;
    logic [GEN_W-1:0]  hgen;
    logic [CNT_W-1:0]  live_m1;
    logic [CNT_W-1:0]  free_m1;
    logic [SLOT_W-1:0] last;
    logic [SLOT_W-1:0] live_idx;
    logic [CNT_W:0]    ids_total;
    logic [SLOT_W-1:0] map_slot;
    logic              map_ok;
    logic [LIM_W-1:0]  comp_lim;
    logic [SLOT_W-1:0] create_id;
    logic [GEN_W-1:0]  create_gen;
    logic [SIG_W-1:0]  bit_mask;
    logic [SIG_W-1:0]  new_sig;
    logic              is_set;
    logic              moving;
    logic              sig_change;

    logic [SLOT_W-1:0] gen_raddr, sig_raddr;
    logic              gen_re, sig_re;
    logic              gen_we, map_we, sid_we, sig_we;
    logic [SLOT_W-1:0] gen_waddr, map_waddr, sid_waddr, sig_waddr;
    logic [GEN_W-1:0]  gen_wdata;
    logic [SLOT_W:0]   map_wdata;
    logic [SLOT_W-1:0] sid_wdata;
    logic [SIG_W-1:0]  sig_wdata;

    assign hid       = handle_reg[HID_W-1:0];
    assign id        = hid[SLOT_W-1:0];
    assign hgen      = handle_reg[HANDLE_W-1 -: GEN_W];
    assign live_m1   = live_reg - CNT_W'(1);
    assign free_m1   = free_reg - CNT_W'(1);
    assign last      = live_m1[SLOT_W-1:0];
    assign live_idx  = live_reg[SLOT_W-1:0];
    assign ids_total = {1'b0, live_reg} + {1'b0, free_reg};
    assign map_slot  = map_q[SLOT_W-1:0];

    // Handle lookup: id in range, id ever issued, mapped and live
    assign map_ok = ({1'b0, hid} < (HID_W+1)'(CAPACITY))
                 && ((CNT_W+1)'(id) < ids_total)
                 && map_q[SLOT_W]
                 && (CNT_W'(map_slot) < live_reg);

    assign comp_lim = (cfg.comps > CIU_W'(COMP_LIMIT)) ? LIM_W'(COMP_LIMIT)
                                                      : LIM_W'(cfg.comps);

    assign stat.cmd     = cmd_reg;
    assign stat.full    = (live_reg >= CNT_W'(CAPACITY));
    assign stat.comp_ok = (LIM_W'(comp_reg) < comp_lim);
    assign stat.map_ok  = map_ok;
    assign stat.gen_ok  = (gen_q == hgen);

    // Create: reuse the top freed id; slots never filled start at generation one
    assign create_id  = (free_reg != '0) ? stack_q : live_idx;
    assign create_gen = ((live_reg < slot_hw_reg) && (gen_q != '0)) ? gen_q : GEN_W'(1);

    // Component bit update
    assign bit_mask   = SIG_W'(1) << comp_reg[COMP_IDX_W-1:0];
    assign is_set     = |(sig_q & bit_mask);
    assign sig_change = (cmd_reg == CMD_ATTACH) || (cmd_reg == CMD_DETACH);
    always_comb
    begin
        if (cmd_reg == CMD_ATTACH)
        begin
            new_sig = sig_q | bit_mask;
        end
        else if (cmd_reg == CMD_DETACH)
        begin
            new_sig = sig_q & ~bit_mask;
        end
        else
        begin
            new_sig = sig_q;
        end
    end

    assign moving = (slot_reg != last);

    // Read addresses
    assign gen_re    = ctl.load | ctl.rd_slot | ctl.rd_last;
    assign sig_re    = ctl.rd_slot | ctl.rd_last;
    assign gen_raddr = ctl.rd_slot ? map_slot : (ctl.rd_last ? last : live_idx);
    assign sig_raddr = ctl.rd_slot ? map_slot : last;

    // Write ports
    always_comb
    begin
        gen_we    = ctl.do_create | (ctl.do_move & moving) | ctl.do_release;
        map_we    = gen_we;
        sid_we    = ctl.do_create | (ctl.do_move & moving);
        sig_we    = sid_we | (ctl.do_comp & sig_change);
        gen_waddr = last;
        gen_wdata = hgen + GEN_W'(1);
        map_waddr = id;
        map_wdata = '0;
        sid_waddr = slot_reg;
        sid_wdata = sid_q;
        sig_waddr = slot_reg;
        sig_wdata = new_sig;
        priority if (ctl.do_create)
        begin
            gen_waddr = live_idx;
            gen_wdata = create_gen;
            map_waddr = create_id;
            map_wdata = {1'b1, live_idx};
            sid_waddr = live_idx;
            sid_wdata = create_id;
            sig_waddr = live_idx;
            sig_wdata = '0;
        end
        else if (ctl.do_move)
        begin
            gen_waddr = slot_reg;
            gen_wdata = gen_q;
            map_waddr = sid_q;
            map_wdata = {1'b1, slot_reg};
            sig_wdata = sig_q;
        end
        else
        begin
            gen_waddr = last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (ctl.load)
        begin
            map_q <= map_mem[in_handle[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_we)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        if (gen_re)
        begin
            gen_q <= gen_mem[gen_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sid_we)
        begin
            sid_mem[sid_waddr] <= sid_wdata;
        end
        if (ctl.rd_last)
        begin
            sid_q <= sid_mem[last];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sig_we)
        begin
            sig_mem[sig_waddr] <= sig_wdata;
        end
        if (sig_re)
        begin
            sig_q <= sig_mem[sig_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.do_release)
        begin
            stack_mem[free_reg[SLOT_W-1:0]] <= id;
        end
        if (ctl.load)
        begin
            stack_q <= stack_mem[free_m1[SLOT_W-1:0]];
        end
    end

    // Advance the counters
    always_comb
    begin
        live_next    = live_reg;
        free_next    = free_reg;
        slot_hw_next = slot_hw_reg;
        if (ctl.do_create)
        begin
            live_next = live_reg + CNT_W'(1);
            if (free_reg != '0)
            begin
                free_next = free_m1;
            end
            if (live_reg == slot_hw_reg)
            begin
                slot_hw_next = slot_hw_reg + CNT_W'(1);
            end
        end
        else if (ctl.do_release)
        begin
            live_next = live_m1;
            free_next = free_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg    <= '0;
            free_reg    <= '0;
            slot_hw_reg <= '0;
        end
        else
        begin
            live_reg    <= live_next;
            free_reg    <= free_next;
            slot_hw_reg <= slot_hw_next;
        end
    end

    // Result beat
    always_comb
    begin
        res_next               = '0;
        res_next.status        = ST_INVALID;
        res_next.entity_handle = handle_reg;
        res_next.live_entities = live_reg;
        unique case (ctl.res_kind)
            RK_INVALID:
            begin
                res_next.status = ST_INVALID;
            end
            RK_FULL:
            begin
                res_next.status        = ST_FULL;
                res_next.entity_handle = '0;
            end
            RK_BADCOMP:
            begin
                res_next.status = ST_BADCOMP;
            end
            RK_CREATE:
            begin
                res_next.status        = ST_OK;
                res_next.entity_handle = {create_gen, HID_W'(create_id)};
                res_next.slot          = live_idx;
                res_next.system_match  = match_mask('0, cfg);
                res_next.live_entities = live_reg + CNT_W'(1);
            end
            RK_DESTROY:
            begin
                res_next.status        = ST_OK;
                res_next.slot          = slot_reg;
                res_next.live_entities = live_m1;
            end
            RK_COMP:
            begin
                res_next.status       = ((cmd_reg == CMD_ATTACH) && is_set) ? ST_ATTACHED
                                                                           : ST_OK;
                res_next.slot         = slot_reg;
                res_next.signature    = new_sig;
                res_next.present      = (cmd_reg == CMD_QUERY) && is_set;
                res_next.system_match = match_mask(new_sig, cfg);
            end
            default:
            begin
                res_next.status = ST_INVALID;
            end
        endcase
    end

    // Hold request fields and the result
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= in_cmd;
            handle_reg <= in_handle;
            comp_reg   <= in_component;
        end
        if (ctl.rd_slot)
        begin
            slot_reg <= map_slot;
        end
        if (ctl.res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

FILE: hw/rtl/generational_entity_slot_table_top.sv
// Top level of the generational entity slot table.
// Keeps up to 1024 live entities in densely packed slots, named by 32-bit handles (8-bit
// generation over a 24-bit id), with a stack of freed ids. Create, and a request rejected
// on its component number or its id map, give their result after the id map read; query,
// attach, detach and a request rejected on its generation give theirs after the slot read;
// a destroy goes on through the last slot read and then the move and release writes. The
// steps follow the chain of dependent single-port table accesses, and a result that is due
// waits while the previous result beat still waits for ready. One request is in flight at
// a time, and the next is accepted while the previous result beat waits in the output
// register. No clearing pass is needed after reset: never-written table entries are
// screened by fill counts. Configuration is written over APB at byte address 4*i for
// register i.
module generational_entity_slot_table_top import gest_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    gest_in_if.sink               in_ch,
    gest_out_if.source            out_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    ctl_cmd_t  ctl;
    ctl_stat_t stat;
    result_t   res;

    gest_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gest_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    gest_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .ctl          (ctl),
        .stat         (stat),
        .in_cmd       (in_ch.cmd),
        .in_handle    (in_ch.handle),
        .in_component (in_ch.component),
        .res          (res)
    );

    // Drive the result beat
    assign out_ch.status        = res.status;
    assign out_ch.entity_handle = res.entity_handle;
    assign out_ch.slot          = res.slot;
    assign out_ch.signature     = res.signature;
    assign out_ch.present       = res.present;
    assign out_ch.system_match  = res.system_match;
    assign out_ch.live_entities = res.live_entities;

endmodule
